### hdl/lzss_pkg.sv
package lzss_pkg;

	// Format constants
	localparam int WINDOW_SIZE_DEF = 4096;
	localparam int OFS_W           = 12;
	localparam int START_POS       = 4078;
	localparam int MIN_RUN         = 3;
	localparam int RUN_W           = 5;
	localparam int PIX_CNT_W       = 24;
	localparam logic [PIX_CNT_W-1:0] FRAME_PIXELS_RST = 24'd76800;
	localparam logic [3:0] GROUP_TOKENS = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	// What the next byte of the stream is
	typedef enum logic [1:0] {
		PH_FLAG      = 2'd0,
		PH_TOKEN     = 2'd1,
		PH_OFFSET_HI = 2'd2
	} phase_t;

	// Control from the sequencer to the window
	typedef struct packed {
		logic             init;
		logic             rd_en;
		logic [OFS_W-1:0] rd_addr;
		logic             wr_en;
		logic [7:0]       wr_data;
	} win_ctl_t;

endpackage

### hdl/lzss_if.sv
// Compressed byte stream
interface lzss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       frame_start;
	modport source(output valid, in_byte, frame_start, input ready);
	modport sink(input valid, in_byte, frame_start, output ready);
endinterface

// Decoded pixel stream
interface lzss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_index;
	logic       run_last;
	logic       frame_full;
	modport source(output valid, pixel_index, run_last, frame_full, input ready);
	modport sink(input valid, pixel_index, run_last, frame_full, output ready);
endinterface

// Frame size register write
interface lzss_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] frame_pixels;
	modport source(output valid, frame_pixels, input ready);
	modport sink(input valid, frame_pixels, output ready);
endinterface

### hdl/lzss_ram.sv
module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/lzss_win.sv
module lzss_win #(
	parameter int WINDOW_SIZE = lzss_pkg::WINDOW_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lzss_pkg::win_ctl_t ctl,
	output logic [7:0]         rd_data
);
	import lzss_pkg::*;

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam logic [AW-1:0] START = AW'(START_POS);

	logic [AW-1:0] wpos_q;
	logic [AW:0]   fill_q;   // entries written since frame start, saturates at depth
	logic          hit_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] rel;
	logic          hit;
	logic [7:0]    ram_data;

	// Writes fill a contiguous span from START; anything outside reads as zero
	assign rd_addr = AW'(ctl.rd_addr);
	assign rel     = rd_addr - START;
	assign hit     = fill_q[AW] | (rel < fill_q[AW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= START;
			fill_q <= '0;
			hit_q  <= 1'b0;
		end else if (ctl.init) begin
			wpos_q <= START;
			fill_q <= '0;
		end else begin
			if (ctl.wr_en) begin
				wpos_q <= wpos_q + 1'b1;
				if (!fill_q[AW]) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (ctl.rd_en) begin
				hit_q <= hit;
			end
		end
	end

	lzss_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_SIZE)
	) u_ram (
		.clk    (clk),
		.wr_en  (ctl.wr_en & ~ctl.init),
		.wr_addr(wpos_q),
		.wr_data(ctl.wr_data),
		.rd_en  (ctl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_data)
	);

	assign rd_data = hit_q ? ram_data : 8'd0;

endmodule

### hdl/lzss_pixel_decompressor_core.sv
// Flag bytes and first offset bytes: no pixel; ready again next cycle.
// Literal: ST_EMIT registers the pixel once the output slot is free, then idles.
// Back-reference: a window read (ST_READ), then emit and window write (ST_EMIT)
// per pixel, 3..18 pixels, each waiting on the registered read and a free slot.
// arst_n clears all control state; the window needs no clearing pass, a fill
// count makes never-written entries read as zero after reset and frame start.
module lzss_pixel_decompressor_core #(
	parameter int WINDOW_SIZE = lzss_pkg::WINDOW_SIZE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	lzss_in_if.sink    pix_in,
	lzss_out_if.source pix_out,
	lzss_cfg_if.sink   cfg
);
	import lzss_pkg::*;

	state_t                 state_q, state_d;
	phase_t                 phase_q, phase_d;
	logic [7:0]             flags_q, flags_d;
	logic [3:0]             left_q, left_d;
	logic [7:0]             held_q, held_d;
	logic [PIX_CNT_W-1:0]   pixels_q, pixels_d;
	logic                   done_q, done_d;
	logic [PIX_CNT_W-1:0]   fp_q;
	logic                   lit_q, lit_d;
	logic [7:0]             byte_q, byte_d;
	logic [OFS_W-1:0]       base_q, base_d;
	logic [RUN_W-1:0]       run_q, run_d;
	logic [RUN_W-1:0]       k_q, k_d;
	logic                   out_valid_q;
	logic [7:0]             pix_q;
	logic                   last_q, full_q;

	win_ctl_t               ctl;
	logic [7:0]             win_data;
	logic [7:0]             px;
	logic                   slot_free;
	logic                   emit;
	logic                   ge;
	logic                   full;
	logic                   last;
	logic [3:0]             left_dec;
	logic [PIX_CNT_W-1:0]   pixels_inc;

	// Shared compare against the frame size
	assign pixels_inc = pixels_q + 1'b1;
	assign ge         = pixels_q >= fp_q;
	assign full       = pixels_inc == fp_q;
	assign left_dec   = left_q - 1'b1;

	assign px        = lit_q ? byte_q : win_data;
	assign slot_free = ~out_valid_q | pix_out.ready;
	assign last      = lit_q | full | (k_q == RUN_W'(run_q - 1'b1));

	assign pix_in.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;

	// Sequencer: next state and window control
	always_comb begin
		state_d        = state_q;
		phase_d        = phase_q;
		flags_d        = flags_q;
		left_d         = left_q;
		held_d         = held_q;
		pixels_d       = pixels_q;
		done_d         = done_q;
		lit_d          = lit_q;
		byte_d         = byte_q;
		base_d         = base_q;
		run_d          = run_q;
		k_d            = k_q;
		emit           = 1'b0;
		ctl            = '0;
		ctl.rd_addr    = base_q + OFS_W'(k_q);
		ctl.wr_data    = px;
		case (state_q)
			ST_IDLE: begin
				if (pix_in.valid) begin
					if (pix_in.frame_start) begin
						// New frame: reset, and this byte is a flag byte
						ctl.init = 1'b1;
						flags_d  = pix_in.in_byte;
						left_d   = GROUP_TOKENS;
						phase_d  = PH_TOKEN;
						held_d   = 8'd0;
						pixels_d = '0;
						done_d   = 1'b0;
					end else if (!done_q) begin
						case (phase_q)
							PH_TOKEN: begin
								if (flags_q[0]) begin
									lit_d   = 1'b1;
									byte_d  = pix_in.in_byte;
									state_d = ST_EMIT;
								end else begin
									held_d  = pix_in.in_byte;
									phase_d = PH_OFFSET_HI;
								end
							end
							PH_OFFSET_HI: begin
								lit_d   = 1'b0;
								base_d  = {pix_in.in_byte[7:4], held_q};
								run_d   = RUN_W'(pix_in.in_byte[3:0]) + RUN_W'(MIN_RUN);
								k_d     = '0;
								state_d = ST_READ;
							end
							default: begin
								flags_d = pix_in.in_byte;
								left_d  = GROUP_TOKENS;
								phase_d = PH_TOKEN;
							end
						endcase
					end
				end
			end
			ST_READ: begin
				ctl.rd_en = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (ge) begin
					// Frame already full: suppress, close the token
					done_d  = 1'b1;
					flags_d = flags_q >> 1;
					left_d  = left_dec;
					phase_d = (left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
					state_d = ST_IDLE;
				end else if (slot_free) begin
					emit      = 1'b1;
					ctl.wr_en = 1'b1;
					pixels_d  = pixels_inc;
					if (full) begin
						done_d = 1'b1;
					end
					if (last) begin
						flags_d = flags_q >> 1;
						left_d  = left_dec;
						phase_d = (left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_FLAG;
			flags_q     <= 8'd0;
			left_q      <= 4'd0;
			held_q      <= 8'd0;
			pixels_q    <= '0;
			done_q      <= 1'b0;
			fp_q        <= FRAME_PIXELS_RST;
			lit_q       <= 1'b0;
			run_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			flags_q  <= flags_d;
			left_q   <= left_d;
			held_q   <= held_d;
			pixels_q <= pixels_d;
			done_q   <= done_d;
			lit_q    <= lit_d;
			run_q    <= run_d;
			k_q      <= k_d;
			if (cfg.valid) begin
				fp_q <= cfg.frame_pixels;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		base_q <= base_d;
		if (emit) begin
			pix_q  <= px;
			last_q <= last;
			full_q <= full;
		end
	end

	lzss_win #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd_data(win_data)
	);

	assign pix_out.valid       = out_valid_q;
	assign pix_out.pixel_index = pix_q;
	assign pix_out.run_last    = last_q;
	assign pix_out.frame_full  = full_q;

endmodule

### hdl/lzss_chk.sv
module lzss_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pixel_index,
	input logic       run_last,
	input logic       frame_full
);

	// A stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_index)
			&& $stable(run_last) && $stable(frame_full))
		else $error("pixel beat changed while stalled");

	// Mid-run pixel pending means the sequencer is still busy
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input taken in the middle of a run");

	// The completing pixel closes its run
	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_full |-> run_last)
		else $error("frame completed without run end");

	// A new pixel only comes from a busy cycle
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("pixel appeared while idle");

	// An offered byte stays offered until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("byte withdrawn before it was taken");

endmodule

bind lzss_pixel_decompressor_core lzss_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pix_in.valid),
	.in_ready   (pix_in.ready),
	.out_valid  (pix_out.valid),
	.out_ready  (pix_out.ready),
	.pixel_index(pix_out.pixel_index),
	.run_last   (pix_out.run_last),
	.frame_full (pix_out.frame_full)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import lzss_pkg::*;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_start;
	} stream_byte_t;

	typedef struct packed {
		logic [7:0] pixel_index;
		logic       run_last;
		logic       frame_full;
	} pixel_t;

	logic clk;
	logic arst_n;

	lzss_in_if  pix_in();
	lzss_out_if pix_out();
	lzss_cfg_if cfg();

	lzss_pixel_decompressor_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in),
		.pix_out(pix_out),
		.cfg    (cfg)
	);

	// Stream bytes waiting to go out, decoded pixels waiting to come back
	stream_byte_t byte_queue[$];
	pixel_t       pixel_expect[$];
	pixel_t       step_pixels[$];

	int  mismatches  = 0;
	bit  in_taken    = 0;
	bit  steady      = 0;
	int  hold_req    = 0;
	int  hold_served = 0;
	int  hold_left   = 0;

	// Decoder shadow state
	logic [7:0]           hist [0:WINDOW_SIZE_DEF-1];
	logic [OFS_W-1:0]     wr_pos;
	logic [7:0]           tok_flags;
	logic [3:0]           tok_left;
	phase_t               phase;
	logic [7:0]           ofs_low;
	logic [PIX_CNT_W-1:0] pixels_out;
	logic                 frame_done;
	logic [PIX_CNT_W-1:0] frame_pixels_cfg;

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard limit on run time
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic void frame_reset();
		foreach (hist[i]) hist[i] = 8'h00;
		wr_pos     = OFS_W'(START_POS);
		tok_flags  = 8'h00;
		tok_left   = 4'd0;
		phase      = PH_FLAG;
		ofs_low    = 8'h00;
		pixels_out = '0;
		frame_done = 1'b0;
	endfunction

	// One pixel into the window and the result list, unless the frame is full
	function automatic bit place_pixel(input logic [7:0] px);
		pixel_t p;
		if (frame_done || pixels_out >= frame_pixels_cfg) begin
			frame_done = 1'b1;
			return 1'b0;
		end
		hist[wr_pos] = px;
		wr_pos       = wr_pos + 1'b1;
		pixels_out   = pixels_out + 1'b1;
		p.pixel_index = px;
		p.run_last    = 1'b0;
		p.frame_full  = 1'b0;
		if (pixels_out >= frame_pixels_cfg) begin
			frame_done   = 1'b1;
			p.frame_full = 1'b1;
		end
		step_pixels.push_back(p);
		return 1'b1;
	endfunction

	function automatic void close_token();
		tok_flags = tok_flags >> 1;
		tok_left  = tok_left - 1'b1;
		phase     = (tok_left == 4'd0) ? PH_FLAG : PH_TOKEN;
	endfunction

	// Expected pixels for one accepted stream byte
	function automatic void decode_byte(input logic [7:0] b, input logic fs);
		logic [OFS_W-1:0] src;
		int               run_len;
		step_pixels.delete();
		if (fs)
			frame_reset();
		if (frame_done)
			return;
		case (phase)
			PH_TOKEN: begin
				if (tok_flags[0]) begin
					void'(place_pixel(b));
					close_token();
				end else begin
					ofs_low = b;
					phase   = PH_OFFSET_HI;
				end
			end
			PH_OFFSET_HI: begin
				src     = {b[7:4], ofs_low};
				run_len = int'(b[3:0]) + MIN_RUN;
				for (int k = 0; k < run_len; k++) begin
					if (!place_pixel(hist[src]))
						break;
					if (frame_done)
						break;
					src = src + 1'b1;
				end
				close_token();
			end
			default: begin
				tok_flags = b;
				tok_left  = GROUP_TOKENS;
				phase     = PH_TOKEN;
			end
		endcase
		if (step_pixels.size() != 0)
			step_pixels[step_pixels.size()-1].run_last = 1'b1;
		foreach (step_pixels[i]) pixel_expect.push_back(step_pixels[i]);
	endfunction

	// Input beat capture and prediction
	always @(posedge clk) begin
		in_taken = arst_n && pix_in.valid && pix_in.ready;
		if (!arst_n) begin
			frame_reset();
		end else if (in_taken) begin
			decode_byte(pix_in.in_byte, pix_in.frame_start);
			void'(byte_queue.pop_front());
		end
	end

	// Byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_in.valid <= 1'b0;
		end else if (!pix_in.valid || in_taken) begin
			if (byte_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
				pix_in.valid       <= 1'b1;
				pix_in.in_byte     <= byte_queue[0].in_byte;
				pix_in.frame_start <= byte_queue[0].frame_start;
			end else begin
				pix_in.valid <= 1'b0;
			end
		end
	end

	// Pixel sink ready, with an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_out.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			pix_out.ready <= 1'b0;
		end else if (hold_served != hold_req) begin
			hold_served = hold_req;
			hold_left   = 300;
			pix_out.ready <= 1'b0;
		end else begin
			pix_out.ready <= steady || $urandom_range(0, 99) >= 29;
		end
	end

	// Pixel monitor
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (pixel_expect.size() == 0) begin
				$error("pixel with none expected: pixel_index %0h run_last %0b frame_full %0b",
					pix_out.pixel_index, pix_out.run_last, pix_out.frame_full);
				mismatches++;
			end else begin
				want = pixel_expect.pop_front();
				if (pix_out.pixel_index !== want.pixel_index) begin
					$error("pixel_index: expected %0h, got %0h",
						want.pixel_index, pix_out.pixel_index);
					mismatches++;
				end
				if (pix_out.run_last !== want.run_last) begin
					$error("run_last: expected %0b, got %0b", want.run_last, pix_out.run_last);
					mismatches++;
				end
				if (pix_out.frame_full !== want.frame_full) begin
					$error("frame_full: expected %0b, got %0b",
						want.frame_full, pix_out.frame_full);
					mismatches++;
				end
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic fs);
		stream_byte_t s;
		s.in_byte     = b;
		s.frame_start = fs;
		byte_queue.push_back(s);
	endtask

	// Wait until every byte is taken and every pixel is back, plus some slack
	task automatic wait_drained();
		while (byte_queue.size() != 0 || pix_in.valid || pixel_expect.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_frame_pixels(input logic [PIX_CNT_W-1:0] v);
		@(negedge clk);
		cfg.valid        <= 1'b1;
		cfg.frame_pixels <= v;
		do
			@(posedge clk);
		while (!cfg.ready);
		frame_pixels_cfg = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// A well-formed frame with random tokens, some noise mixed in.
	// Offsets mostly point just behind the write position so copies see data.
	task automatic queue_frame(input int n_bytes);
		int               placed;
		logic [OFS_W-1:0] pos_guess;
		logic [OFS_W-1:0] ofs;
		logic [3:0]       len;
		logic [7:0]       flags;
		placed    = 0;
		pos_guess = OFS_W'(START_POS);
		while (placed < n_bytes) begin
			flags = 8'($urandom);
			push_byte(flags, placed == 0);
			placed++;
			for (int t = 0; t < 8 && placed < n_bytes; t++) begin
				if ($urandom_range(0, 99) < 6) begin
					push_byte(8'($urandom), $urandom_range(0, 7) == 0);
					placed++;
				end
				if (flags[t]) begin
					push_byte(8'($urandom), 1'b0);
					placed++;
					pos_guess = pos_guess + 1'b1;
				end else begin
					len = 4'($urandom);
					if ($urandom_range(0, 3) == 0)
						ofs = OFS_W'($urandom);
					else
						ofs = pos_guess - OFS_W'($urandom_range(1, 24));
					push_byte(ofs[7:0], 1'b0);
					push_byte({ofs[11:8], len}, 1'b0);
					placed += 2;
					pos_guess = pos_guess + len + OFS_W'(MIN_RUN);
				end
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg.valid          = 1'b0;
		cfg.frame_pixels   = '0;
		frame_pixels_cfg   = FRAME_PIXELS_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Stream before any frame start: literal, longest copy from the start
		// position, copy wrapping past the window end, shortest copy at zero
		push_byte(8'h05, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hEE, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		// New frame, two literals
		push_byte(8'hFF, 1'b1);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h55, 1'b0);
		wait_drained();

		// Frame size lowered below the count: next pixel suppressed, rest ignored
		write_frame_pixels(24'd1);
		push_byte(8'h80, 1'b0);
		push_byte(8'h12, 1'b0);
		// One-pixel frame: a long copy cut at its first pixel
		push_byte(8'h00, 1'b1);
		push_byte(8'h10, 1'b0);
		push_byte(8'h3F, 1'b0);
		push_byte(8'h77, 1'b0);
		wait_drained();

		// Largest frame; frame start landing in the middle of a back-reference
		write_frame_pixels(24'hFFFFFF);
		push_byte(8'hAA, 1'b1);
		push_byte(8'h03, 1'b0);
		push_byte(8'h0F, 1'b0);
		push_byte(8'h81, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h7E, 1'b1);
		push_byte(8'h42, 1'b0);
		wait_drained();

		// Random frames, receiver holding off long enough to back up the input
		write_frame_pixels(24'($urandom_range(40, 150)));
		hold_req = hold_req + 1;
		queue_frame(18);
		queue_frame(18);
		wait_drained();

		// Random frames with no idling on either side
		write_frame_pixels(24'($urandom_range(20, 120)));
		steady = 1;
		queue_frame(15);
		queue_frame(15);
		wait_drained();
		steady = 0;

		// Random frames at the reset frame size
		write_frame_pixels(FRAME_PIXELS_RST);
		queue_frame(15);
		queue_frame(15);
		wait_drained();

		if (mismatches == 0 && pixel_expect.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
